[rtl/trdb_pkg.sv]
// Shared types and constants of the triangle rasterizer with depth buffer.
package trdb_pkg;

  localparam int DEPTH_W  = 24;
  localparam int ID_W     = 16;
  localparam int COORD_W  = 16;
  localparam int CNT_W    = 13;
  localparam int CFG_W    = 7;
  localparam int IDX_W    = 12;

  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 64;

  // Signed width of edge values and bounding box coordinates.
  localparam int EW = 36;
  localparam int BW = 14;
  // Unsigned width of the area and of edge values inside the triangle.
  localparam int UW = 34;
  localparam int NUM_W = UW + DEPTH_W + 2;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;
  localparam logic [ID_W-1:0]    ID_BG     = '1;

  localparam logic [1:0] OP_DRAW  = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic [1:0]                operation;
    logic signed [COORD_W-1:0] vertex_a_x;
    logic signed [COORD_W-1:0] vertex_a_y;
    logic [DEPTH_W-1:0]        vertex_a_depth;
    logic signed [COORD_W-1:0] vertex_b_x;
    logic signed [COORD_W-1:0] vertex_b_y;
    logic [DEPTH_W-1:0]        vertex_b_depth;
    logic signed [COORD_W-1:0] vertex_c_x;
    logic signed [COORD_W-1:0] vertex_c_y;
    logic [DEPTH_W-1:0]        vertex_c_depth;
    logic [ID_W-1:0]           triangle_id;
    logic [IDX_W-1:0]          pixel_index;
  } in_item_t;

  typedef struct packed {
    logic [CNT_W-1:0]   pixels_written;
    logic [DEPTH_W-1:0] stored_depth;
    logic [ID_W-1:0]    stored_id;
  } out_item_t;

endpackage

[rtl/trdb_store.sv]
// Depth and id memories with one write port and one registered read port.
module trdb_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic [trdb_pkg::DEPTH_W-1:0] wdepth,
  input  logic [trdb_pkg::ID_W-1:0]    wid,
  input  logic                         re,
  input  logic [AW-1:0]                raddr,
  output logic [trdb_pkg::DEPTH_W-1:0] rdepth,
  output logic [trdb_pkg::ID_W-1:0]    rid
);

  logic [trdb_pkg::DEPTH_W-1:0] dmem [DEPTH];
  logic [trdb_pkg::ID_W-1:0]    imem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      dmem[waddr] <= wdepth;
      imem[waddr] <= wid;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdepth <= dmem[raddr];
      rid    <= imem[raddr];
    end
  end

endmodule

[rtl/trdb_div.sv]
// Restoring divider, one quotient bit per cycle, for the depth interpolation.
module trdb_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [trdb_pkg::NUM_W-1:0]   num,
  input  logic [trdb_pkg::UW-1:0]      den,
  output logic                         done,
  output logic [trdb_pkg::DEPTH_W-1:0] quot
);

  localparam int QW = trdb_pkg::DEPTH_W;
  localparam int UW = trdb_pkg::UW;

  logic [UW-1:0]          rem_r, rem_nxt;
  logic [QW-1:0]          low_r, low_nxt;
  logic [QW-1:0]          q_r, q_nxt;
  logic [$clog2(QW)-1:0]  cnt_r, cnt_nxt;
  logic                   run_r, run_nxt;
  logic                   done_r, done_nxt;
  logic [UW:0]            trial;
  logic                   ge;

  // The quotient is known to be below 2^QW, so the top bits start as the remainder.
  always_comb begin
    trial    = {rem_r, low_r[QW-1]};
    ge       = (trial >= {1'b0, den});
    rem_nxt  = rem_r;
    low_nxt  = low_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = num[QW +: UW];
      low_nxt = num[QW-1:0];
      q_nxt   = '0;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt = ge ? UW'(trial - {1'b0, den}) : trial[UW-1:0];
      low_nxt = {low_r[QW-2:0], 1'b0};
      q_nxt   = {q_r[QW-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == ($clog2(QW))'(QW - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    low_r <= low_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

[rtl/triangle_rasterizer_depth_buffer.sv]
// Top level of the triangle rasterizer with depth and id buffers.
//
// A transaction is accepted on a rising edge with start high and busy low.
// Operation draw rasterizes one triangle into the depth and id memories,
// clear sets both whole memories to all ones, read returns one pixel.
// Every transaction returns exactly one result on out_item, marked by a
// one-cycle out_valid strobe; the receiver cannot stall, so the result is
// simply taken in that cycle.
// Draw: the setup states SET0, SET1 and SET2, then per pixel of the clamped
// bounding box the states PE, PT and NX when its centre is outside, or PE,
// PT, PM, PS, DV, WR and NX when inside (edge products, depth products, the
// one-bit-per-cycle divider that floors the interpolated depth, and the
// depth-compare write back), then the closing state FIN before the result.
// The divider sets the time. Clear: one memory entry per cycle over all
// MAX_WIDTH*MAX_HEIGHT entries, then the result. Read: states RD0 and RD1.
// An unused operation answers at once. After reset the block runs the same
// clearing pass, busy high, no result; frame size registers return to 64.
// The APB port is usable at all times; frame width lies at byte address 0
// and frame height at 4. Write it only while the block is idle.
module triangle_rasterizer_depth_buffer #(
  parameter int MAX_WIDTH  = trdb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = trdb_pkg::MAX_HEIGHT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  trdb_pkg::in_item_t  in_item,
  output logic                out_valid,
  output trdb_pkg::out_item_t out_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int SIZE = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW   = (SIZE > 1) ? $clog2(SIZE) : 1;
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int EW   = trdb_pkg::EW;
  localparam int BW   = trdb_pkg::BW;
  localparam int UW   = trdb_pkg::UW;
  localparam int NW   = trdb_pkg::NUM_W;
  localparam int DW   = trdb_pkg::DEPTH_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR  = 4'd1;
  localparam logic [3:0] S_RD0  = 4'd2;
  localparam logic [3:0] S_RD1  = 4'd3;
  localparam logic [3:0] S_SET0 = 4'd4;
  localparam logic [3:0] S_SET1 = 4'd5;
  localparam logic [3:0] S_SET2 = 4'd6;
  localparam logic [3:0] S_PE   = 4'd7;
  localparam logic [3:0] S_PT   = 4'd8;
  localparam logic [3:0] S_PM   = 4'd9;
  localparam logic [3:0] S_PS   = 4'd10;
  localparam logic [3:0] S_DV   = 4'd11;
  localparam logic [3:0] S_WR   = 4'd12;
  localparam logic [3:0] S_NX   = 4'd13;
  localparam logic [3:0] S_FIN  = 4'd14;

  logic [3:0] state_r, state_nxt;

  // Configuration registers and their effective values.
  logic [trdb_pkg::CFG_W-1:0] frame_w_r, frame_w_nxt, frame_h_r, frame_h_nxt;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    frame_w_nxt = frame_w_r;
    frame_h_nxt = frame_h_r;
    if (cfg_wr) begin
      if (paddr[2] == trdb_pkg::REG_FRAME_WIDTH) begin
        frame_w_nxt = pwdata[trdb_pkg::CFG_W-1:0];
      end else begin
        frame_h_nxt = pwdata[trdb_pkg::CFG_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == trdb_pkg::REG_FRAME_HEIGHT) ? 32'(frame_h_r) : 32'(frame_w_r);

  // A zero size acts as one, a size above the maximum acts as the maximum.
  always_comb begin
    if (frame_w_r == '0) begin
      w_eff = WW'(1);
    end else if (int'(frame_w_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_w_r);
    end
    if (frame_h_r == '0) begin
      h_eff = HW'(1);
    end else if (int'(frame_h_r) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(frame_h_r);
    end
  end

  // Captured transaction and setup values.
  trdb_pkg::in_item_t item_r, item_nxt;
  logic signed [16:0] bdy_r, cbx_r, cay_r, acx_r, ady_r;
  logic signed [16:0] bdy_nxt, cbx_nxt, cay_nxt, acx_nxt, ady_nxt;
  logic signed [BW-1:0] x0_r, x1_r, y0_r, y1_r, x_r, y_r;
  logic signed [BW-1:0] x0_nxt, x1_nxt, y0_nxt, y1_nxt, x_nxt, y_nxt;
  logic signed [EW-1:0] pa_r, pb_r, pa_nxt, pb_nxt;
  logic signed [EW-1:0] q0_r, q1_r, q2_r, q3_r, q0_nxt, q1_nxt, q2_nxt, q3_nxt;
  logic [UW-1:0] area_r, area_nxt, e0_r, e1_r, e2_r, e0_nxt, e1_nxt, e2_nxt;
  logic          neg_r, neg_nxt;
  logic [NW-1:0] m0_r, m1_r, m2_r, m0_nxt, m1_nxt, m2_nxt;
  logic [AW-1:0] row_r, row_nxt, clr_r, clr_nxt;
  logic          clr_op_r, clr_op_nxt, hit_r, hit_nxt;
  logic [trdb_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  trdb_pkg::out_item_t out_r, out_nxt;

  // Memory and divider connections.
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr, pix_addr;
  logic [DW-1:0] mem_wdepth, mem_rdepth;
  logic [trdb_pkg::ID_W-1:0] mem_wid, mem_rid;
  logic          div_start, div_done;
  logic [DW-1:0] div_quot;
  logic [NW-1:0] num_sum;

  // Combinational helpers.
  logic signed [trdb_pkg::COORD_W-1:0] xmin, xmax, ymin, ymax;
  logic signed [16:0] xmax_p, ymax_p;
  logic signed [BW-1:0] fx, fy, cxv, cyv, wm1, hm1;
  logic signed [17:0] px, py, dpx, dpy;
  logic signed [EW-1:0] area_s, s0, s1, e0s, e1s, e2s;
  logic [21:0] lim;

  assign pix_addr = row_r + AW'(x_r);
  assign num_sum  = m0_r + m1_r + m2_r;
  assign lim      = 22'(w_eff * h_eff);

  always_comb begin
    xmin = item_r.vertex_a_x;
    if (item_r.vertex_b_x < xmin) xmin = item_r.vertex_b_x;
    if (item_r.vertex_c_x < xmin) xmin = item_r.vertex_c_x;
    xmax = item_r.vertex_a_x;
    if (item_r.vertex_b_x > xmax) xmax = item_r.vertex_b_x;
    if (item_r.vertex_c_x > xmax) xmax = item_r.vertex_c_x;
    ymin = item_r.vertex_a_y;
    if (item_r.vertex_b_y < ymin) ymin = item_r.vertex_b_y;
    if (item_r.vertex_c_y < ymin) ymin = item_r.vertex_c_y;
    ymax = item_r.vertex_a_y;
    if (item_r.vertex_b_y > ymax) ymax = item_r.vertex_b_y;
    if (item_r.vertex_c_y > ymax) ymax = item_r.vertex_c_y;
    // Floor and ceiling of 12.4 fixed point values.
    xmax_p = 17'(xmax) + 17'sd15;
    ymax_p = 17'(ymax) + 17'sd15;
    fx  = BW'(xmin >>> 4);
    fy  = BW'(ymin >>> 4);
    cxv = BW'(xmax_p >>> 4);
    cyv = BW'(ymax_p >>> 4);
    wm1 = $signed(BW'(w_eff)) - BW'(1);
    hm1 = $signed(BW'(h_eff)) - BW'(1);
    // Pixel centre relative to vertex c.
    px  = $signed({x_r, 4'b1000});
    py  = $signed({y_r, 4'b1000});
    dpx = px - 18'(item_r.vertex_c_x);
    dpy = py - 18'(item_r.vertex_c_y);
    area_s = pa_r + pb_r;
    s0  = q0_r + q1_r;
    s1  = q2_r + q3_r;
    e0s = neg_r ? -s0 : s0;
    e1s = neg_r ? -s1 : s1;
    e2s = $signed({2'b0, area_r}) - e0s - e1s;
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    bdy_nxt = bdy_r; cbx_nxt = cbx_r; cay_nxt = cay_r; acx_nxt = acx_r; ady_nxt = ady_r;
    x0_nxt = x0_r; x1_nxt = x1_r; y0_nxt = y0_r; y1_nxt = y1_r;
    x_nxt = x_r; y_nxt = y_r;
    pa_nxt = pa_r; pb_nxt = pb_r;
    q0_nxt = q0_r; q1_nxt = q1_r; q2_nxt = q2_r; q3_nxt = q3_r;
    area_nxt = area_r; neg_nxt = neg_r;
    e0_nxt = e0_r; e1_nxt = e1_r; e2_nxt = e2_r;
    m0_nxt = m0_r; m1_nxt = m1_r; m2_nxt = m2_r;
    row_nxt = row_r; clr_nxt = clr_r; clr_op_nxt = clr_op_r; hit_nxt = hit_r;
    cnt_nxt = cnt_r;
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    mem_we     = 1'b0;
    mem_waddr  = pix_addr;
    mem_wdepth = div_quot;
    mem_wid    = item_r.triangle_id;
    mem_re     = 1'b0;
    mem_raddr  = pix_addr;
    div_start  = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          item_nxt = in_item;
          cnt_nxt  = '0;
          case (in_item.operation)
            trdb_pkg::OP_DRAW:  state_nxt = S_SET0;
            trdb_pkg::OP_CLEAR: begin
              clr_nxt    = '0;
              clr_op_nxt = 1'b1;
              state_nxt  = S_CLR;
            end
            trdb_pkg::OP_READ:  state_nxt = S_RD0;
            default: out_valid_nxt = 1'b1;
          endcase
        end
      end
      S_CLR: begin
        mem_we     = 1'b1;
        mem_waddr  = clr_r;
        mem_wdepth = trdb_pkg::DEPTH_MAX;
        mem_wid    = trdb_pkg::ID_BG;
        clr_nxt    = clr_r + 1'b1;
        if (clr_r == AW'(SIZE - 1)) begin
          out_valid_nxt = clr_op_r;
          state_nxt     = S_IDLE;
        end
      end
      S_RD0: begin
        hit_nxt   = (32'(item_r.pixel_index) < 32'(lim));
        mem_re    = 1'b1;
        mem_raddr = AW'(item_r.pixel_index);
        state_nxt = S_RD1;
      end
      S_RD1: begin
        out_valid_nxt        = 1'b1;
        out_nxt.stored_depth = hit_r ? mem_rdepth : trdb_pkg::DEPTH_MAX;
        out_nxt.stored_id    = hit_r ? mem_rid : trdb_pkg::ID_BG;
        state_nxt            = S_IDLE;
      end
      S_SET0: begin
        bdy_nxt = 17'(item_r.vertex_b_y) - 17'(item_r.vertex_c_y);
        cbx_nxt = 17'(item_r.vertex_c_x) - 17'(item_r.vertex_b_x);
        cay_nxt = 17'(item_r.vertex_c_y) - 17'(item_r.vertex_a_y);
        acx_nxt = 17'(item_r.vertex_a_x) - 17'(item_r.vertex_c_x);
        ady_nxt = 17'(item_r.vertex_a_y) - 17'(item_r.vertex_c_y);
        x0_nxt  = (fx < 0) ? '0 : fx;
        y0_nxt  = (fy < 0) ? '0 : fy;
        x1_nxt  = (cxv > wm1) ? wm1 : cxv;
        y1_nxt  = (cyv > hm1) ? hm1 : cyv;
        state_nxt = S_SET1;
      end
      S_SET1: begin
        pa_nxt    = EW'(bdy_r * acx_r);
        pb_nxt    = EW'(cbx_r * ady_r);
        row_nxt   = AW'(y0_r[BW-2:0] * w_eff);
        x_nxt     = x0_r;
        y_nxt     = y0_r;
        state_nxt = S_SET2;
      end
      S_SET2: begin
        neg_nxt  = area_s[EW-1];
        area_nxt = area_s[EW-1] ? UW'(-area_s) : UW'(area_s);
        // A zero-area triangle or an empty box draws nothing.
        if (area_s == '0 || x0_r > x1_r || y0_r > y1_r) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_PE;
        end
      end
      S_PE: begin
        q0_nxt    = EW'(bdy_r * dpx);
        q1_nxt    = EW'(cbx_r * dpy);
        q2_nxt    = EW'(cay_r * dpx);
        q3_nxt    = EW'(acx_r * dpy);
        mem_re    = 1'b1;
        state_nxt = S_PT;
      end
      S_PT: begin
        e0_nxt = UW'(e0s);
        e1_nxt = UW'(e1s);
        e2_nxt = UW'(e2s);
        if (e0s[EW-1] || e1s[EW-1] || e2s[EW-1]) begin
          state_nxt = S_NX;
        end else begin
          state_nxt = S_PM;
        end
      end
      S_PM: begin
        m0_nxt    = NW'(e0_r * item_r.vertex_a_depth);
        m1_nxt    = NW'(e1_r * item_r.vertex_b_depth);
        m2_nxt    = NW'(e2_r * item_r.vertex_c_depth);
        state_nxt = S_PS;
      end
      S_PS: begin
        div_start = 1'b1;
        state_nxt = S_DV;
      end
      S_DV: begin
        if (div_done) state_nxt = S_WR;
      end
      S_WR: begin
        if (div_quot < mem_rdepth) begin
          mem_we  = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end
        state_nxt = S_NX;
      end
      S_NX: begin
        if (x_r == x1_r) begin
          if (y_r == y1_r) begin
            state_nxt = S_FIN;
          end else begin
            y_nxt     = y_r + BW'(1);
            x_nxt     = x0_r;
            row_nxt   = row_r + AW'(w_eff);
            state_nxt = S_PE;
          end
        end else begin
          x_nxt     = x_r + BW'(1);
          state_nxt = S_PE;
        end
      end
      S_FIN: begin
        out_valid_nxt          = 1'b1;
        out_nxt.pixels_written = cnt_r;
        state_nxt              = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      clr_op_r    <= 1'b0;
      frame_w_r   <= trdb_pkg::CFG_W'(64);
      frame_h_r   <= trdb_pkg::CFG_W'(64);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      clr_op_r    <= clr_op_nxt;
      frame_w_r   <= frame_w_nxt;
      frame_h_r   <= frame_h_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    bdy_r <= bdy_nxt; cbx_r <= cbx_nxt; cay_r <= cay_nxt; acx_r <= acx_nxt; ady_r <= ady_nxt;
    x0_r <= x0_nxt; x1_r <= x1_nxt; y0_r <= y0_nxt; y1_r <= y1_nxt;
    x_r <= x_nxt; y_r <= y_nxt;
    pa_r <= pa_nxt; pb_r <= pb_nxt;
    q0_r <= q0_nxt; q1_r <= q1_nxt; q2_r <= q2_nxt; q3_r <= q3_nxt;
    area_r <= area_nxt; neg_r <= neg_nxt;
    e0_r <= e0_nxt; e1_r <= e1_nxt; e2_r <= e2_nxt;
    m0_r <= m0_nxt; m1_r <= m1_nxt; m2_r <= m2_nxt;
    row_r <= row_nxt; hit_r <= hit_nxt; cnt_r <= cnt_nxt;
    out_r <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  trdb_store #(
    .DEPTH (SIZE),
    .AW    (AW)
  ) u_store (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (mem_waddr),
    .wdepth (mem_wdepth),
    .wid    (mem_wid),
    .re     (mem_re),
    .raddr  (mem_raddr),
    .rdepth (mem_rdepth),
    .rid    (mem_rid)
  );

  trdb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_sum),
    .den   (area_r),
    .done  (div_done),
    .quot  (div_quot)
  );

endmodule
